// File: hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the block's checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, quiet while reset is held.
`define SFD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define SFD_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/sfd_pkg.sv
// ---------------------------------------------------------------------------
// sfd_pkg
// Widths, codes, state encoding and control types of the S.BUS frame decoder.
// ---------------------------------------------------------------------------
package sfd_pkg;

  localparam int FRAME_BYTES   = 25;
  localparam int FOOTER_POS    = FRAME_BYTES - 1;
  localparam int LAST_DATA_POS = 22;
  localparam int BYTE_W        = 8;
  localparam int CH_W          = 11;
  localparam int STORE_DEPTH   = 16;
  localparam int IDX_W         = 4;
  localparam int POS_W         = 5;
  localparam int ACC_W         = 18;
  localparam int BITS_W        = 5;
  localparam int FILL_W        = 5;
  localparam int CNT_W         = 16;
  localparam int CFG_AW        = 3;
  localparam int CFG_DW        = 32;

  localparam logic [BYTE_W-1:0] HEADER_RESET = 8'h0F;
  localparam logic [BYTE_W-1:0] FOOTER_RESET = 8'h00;

  // input item commands
  localparam logic CMD_BYTE    = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  // register select, taken from paddr[2]
  localparam logic REG_HEADER = 1'b0;
  localparam logic REG_FOOTER = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_UNPACK = 5'b00010,
    ST_CHECK  = 5'b00100,
    ST_SEND   = 5'b01000,
    ST_ERR    = 5'b10000
  } sfd_state_t;

  // sequencer -> unpack unit
  typedef struct packed {
    logic               clear;
    logic               take;
    logic [BYTE_W-1:0]  data;
    logic [IDX_W-1:0]   rd_addr;
  } unp_ctl_t;

endpackage

// File: hdl/sfd_in_if.sv
// ---------------------------------------------------------------------------
// sfd_in_if
// Input channel: one received byte or a restart per item.
// ---------------------------------------------------------------------------
interface sfd_in_if;
  logic                        valid;
  logic                        ready;
  logic                        cmd;
  logic [sfd_pkg::BYTE_W-1:0]  rx_byte;

  modport source (output valid, output cmd, output rx_byte, input ready);
  modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface

// File: hdl/sfd_out_if.sv
// ---------------------------------------------------------------------------
// sfd_out_if
// Result channel: one decoded channel or one bad-frame report per item.
// ---------------------------------------------------------------------------
interface sfd_out_if;
  logic                       valid;
  logic                       ready;
  logic                       frame_ok;
  logic [sfd_pkg::IDX_W-1:0]  channel_index;
  logic [sfd_pkg::CH_W-1:0]   channel_value;
  logic [sfd_pkg::CNT_W-1:0]  error_count;
  logic                       last;

  modport source (output valid, output frame_ok, output channel_index,
                  output channel_value, output error_count, output last,
                  input ready);
  modport sink   (input valid, input frame_ok, input channel_index,
                  input channel_value, input error_count, input last,
                  output ready);
endinterface

// File: hdl/sfd_unpack.sv
// ---------------------------------------------------------------------------
// sfd_unpack
// Shift/extract unit and channel store: packs bytes LSB first, cuts 11-bit
// channels, registered read port for the drain.
// ---------------------------------------------------------------------------
module sfd_unpack (
  input  logic                      clk,
  input  logic                      rst_n,
  input  sfd_pkg::unp_ctl_t         ctl_i,
  output logic [sfd_pkg::CH_W-1:0]  rd_data_o
);
  import sfd_pkg::*;

  logic [ACC_W-1:0]  acc_r,    acc_nxt;
  logic [BITS_W-1:0] bits_r,   bits_nxt;
  logic [FILL_W-1:0] filled_r, filled_nxt;
  logic [ACC_W-1:0]  merged;
  logic [BITS_W-1:0] bits_sum;
  logic              extract;

  logic [CH_W-1:0]   store [STORE_DEPTH];
  logic [CH_W-1:0]   rd_data_r;

  // at most one channel completes per byte: 10 + 8 bits < 22
  always_comb begin
    merged   = acc_r | (ACC_W'(ctl_i.data) << bits_r);
    bits_sum = bits_r + BITS_W'(BYTE_W);
    extract  = (bits_sum >= BITS_W'(CH_W)) && (filled_r < FILL_W'(STORE_DEPTH));

    acc_nxt    = acc_r;
    bits_nxt   = bits_r;
    filled_nxt = filled_r;
    if (ctl_i.clear) begin
      acc_nxt    = '0;
      bits_nxt   = '0;
      filled_nxt = '0;
    end else if (ctl_i.take) begin
      if (extract) begin
        acc_nxt    = merged >> CH_W;
        bits_nxt   = bits_sum - BITS_W'(CH_W);
        filled_nxt = filled_r + FILL_W'(1);
      end else begin
        acc_nxt  = merged;
        bits_nxt = bits_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r    <= '0;
      bits_r   <= '0;
      filled_r <= '0;
    end else begin
      acc_r    <= acc_nxt;
      bits_r   <= bits_nxt;
      filled_r <= filled_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_i.take && !ctl_i.clear && extract) begin
      store[filled_r[IDX_W-1:0]] <= merged[CH_W-1:0];
    end
    rd_data_r <= store[ctl_i.rd_addr];
  end

  assign rd_data_o = rd_data_r;

endmodule

// File: hdl/sbus_frame_decoder.sv
// ---------------------------------------------------------------------------
// sbus_frame_decoder
// S.BUS receiver back end: 25-byte frames into sixteen 11-bit channels.
// ---------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-----------------------------------------
//  in_ch   | in  | valid/ready        | cmd, rx_byte
//  out_ch  | out | valid/ready        | frame_ok, channel_index, channel_value,
//          |     |                    | error_count, last
//  cfg_*   | in  | APB, pready tied 1 | header_value @0x0, footer_value @0x4
//
//  Header, data and flags bytes are taken in IDLE; data bytes 1..22 then pass
//  through the shift/extract unit in UNPACK. After the footer byte comes a
//  CHECK state, then a drain of NUM_CHANNELS items (one store read per cycle),
//  or a single error item. in_ch.ready is high only in IDLE; the output
//  register lets IDLE take the next byte while the last result still waits.
//  Output stalls hold the drain; rst_n is synchronous, active low.
// ---------------------------------------------------------------------------
module sbus_frame_decoder #(
  parameter int NUM_CHANNELS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  sfd_in_if.sink                         in_ch,
  sfd_out_if.source                      out_ch,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [sfd_pkg::CFG_AW-1:0]     cfg_paddr,
  input  logic [sfd_pkg::CFG_DW-1:0]     cfg_pwdata,
  output logic [sfd_pkg::CFG_DW-1:0]     cfg_prdata,
  output logic                           cfg_pready
);
  import sfd_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_CHANNELS - 1);

  sfd_state_t        state_r, state_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic              hunting_r, hunting_nxt;
  logic              hdr_ok_r, hdr_ok_nxt;
  logic [BYTE_W-1:0] rx_r, rx_nxt;
  logic [BYTE_W-1:0] header_r, footer_r;
  logic [CNT_W-1:0]  err_cnt_r, err_cnt_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic              out_ok_r, out_ok_nxt;
  logic [IDX_W-1:0]  out_idx_r, out_idx_nxt;
  logic [CH_W-1:0]   out_val_r, out_val_nxt;
  logic [CNT_W-1:0]  out_cnt_r, out_cnt_nxt;
  logic              out_last_r, out_last_nxt;

  logic              in_accept;
  logic              out_free;
  logic              cfg_wr;
  unp_ctl_t          unp_ctl;
  logic [CH_W-1:0]   rd_data;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_accept   = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  // ---- configuration port ----
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == REG_FOOTER) ? CFG_DW'(footer_r) : CFG_DW'(header_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r <= HEADER_RESET;
      footer_r <= FOOTER_RESET;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_FOOTER) begin
        footer_r <= cfg_pwdata[BYTE_W-1:0];
      end else begin
        header_r <= cfg_pwdata[BYTE_W-1:0];
      end
    end
  end

  // ---- sequencer ----
  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    hunting_nxt   = hunting_r;
    hdr_ok_nxt    = hdr_ok_r;
    rx_nxt        = rx_r;
    err_cnt_nxt   = err_cnt_r;
    idx_nxt       = idx_r;

    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_ok_nxt    = out_ok_r;
    out_idx_nxt   = out_idx_r;
    out_val_nxt   = out_val_r;
    out_cnt_nxt   = out_cnt_r;
    out_last_nxt  = out_last_r;

    unp_ctl.clear   = 1'b0;
    unp_ctl.take    = 1'b0;
    unp_ctl.data    = rx_r;
    unp_ctl.rd_addr = idx_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          rx_nxt = in_ch.rx_byte;
          if (in_ch.cmd == CMD_RESTART) begin
            // line gap or UART error: restart framing, keep count and store
            pos_nxt       = '0;
            hunting_nxt   = 1'b0;
            hdr_ok_nxt    = 1'b0;
            unp_ctl.clear = 1'b1;
          end else if (!hunting_r) begin
            if (pos_r == '0) begin
              hdr_ok_nxt    = (in_ch.rx_byte == header_r);
              unp_ctl.clear = 1'b1;
              pos_nxt       = pos_r + POS_W'(1);
            end else if (pos_r <= POS_W'(LAST_DATA_POS)) begin
              pos_nxt   = pos_r + POS_W'(1);
              state_nxt = ST_UNPACK;
            end else if (pos_r == POS_W'(FOOTER_POS)) begin
              state_nxt = ST_CHECK;
            end else begin
              pos_nxt = pos_r + POS_W'(1);   // flags byte, unused
            end
          end
        end
      end
      ST_UNPACK: begin
        unp_ctl.take = 1'b1;
        state_nxt    = ST_IDLE;
      end
      ST_CHECK: begin
        // all 176 data bits always fill the 16 channels by byte 22
        pos_nxt    = '0;
        hdr_ok_nxt = 1'b0;
        if (hdr_ok_r && (rx_r == footer_r)) begin
          idx_nxt         = '0;
          unp_ctl.rd_addr = '0;
          state_nxt       = ST_SEND;
        end else begin
          err_cnt_nxt = err_cnt_r + CNT_W'(1);
          hunting_nxt = 1'b1;
          state_nxt   = ST_ERR;
        end
      end
      ST_SEND: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = 1'b1;
          out_idx_nxt   = idx_r;
          out_val_nxt   = rd_data;
          out_cnt_nxt   = err_cnt_r;
          out_last_nxt  = (idx_r == LAST_IDX);
          if (idx_r == LAST_IDX) begin
            state_nxt = ST_IDLE;
          end else begin
            // prefetch the next channel so the drain runs one per cycle while the output is not stalled
            idx_nxt         = idx_r + IDX_W'(1);
            unp_ctl.rd_addr = idx_r + IDX_W'(1);
          end
        end
      end
      ST_ERR: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = 1'b0;
          out_idx_nxt   = '0;
          out_val_nxt   = '0;
          out_cnt_nxt   = err_cnt_r;
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= '0;
      hunting_r   <= 1'b0;
      hdr_ok_r    <= 1'b0;
      err_cnt_r   <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      hunting_r   <= hunting_nxt;
      hdr_ok_r    <= hdr_ok_nxt;
      err_cnt_r   <= err_cnt_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rx_r       <= rx_nxt;
    out_ok_r   <= out_ok_nxt;
    out_idx_r  <= out_idx_nxt;
    out_val_r  <= out_val_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_last_r <= out_last_nxt;
  end

  sfd_unpack u_unpack (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl_i     (unp_ctl),
    .rd_data_o (rd_data)
  );

  assign out_ch.valid         = out_valid_r;
  assign out_ch.frame_ok      = out_ok_r;
  assign out_ch.channel_index = out_idx_r;
  assign out_ch.channel_value = out_val_r;
  assign out_ch.error_count   = out_cnt_r;
  assign out_ch.last          = out_last_r;

endmodule

// File: hdl/sfd_checker.sv
// ---------------------------------------------------------------------------
// sfd_checker
// Port-level checks of the frame decoder, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sfd_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       in_cmd,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       out_frame_ok,
  input logic [sfd_pkg::IDX_W-1:0]  out_channel_index,
  input logic [sfd_pkg::CH_W-1:0]   out_channel_value,
  input logic                       out_last
);
  import sfd_pkg::*;

  // a result waiting must stay offered
  `SFD_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")

  // no byte is taken in the middle of a frame's drain
  `SFD_ASSERT(a_no_in_mid_drain, out_valid && out_frame_ok && !out_last |-> !in_ready, "input taken during drain")

  // a restart never starts a result
  `SFD_ASSERT(a_restart_quiet, in_valid && in_ready && (in_cmd == CMD_RESTART) |=> !$rose(out_valid), "restart produced a result")

  // error items are single, zero-filled
  `SFD_ASSERT(a_err_shape, out_valid && !out_frame_ok |-> out_last && (out_channel_index == '0) && (out_channel_value == '0), "malformed error item")

  // reset empties the output register
  `SFD_ASSERT_RST(a_reset_empty, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind sbus_frame_decoder sfd_checker u_sfd_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .in_cmd            (in_ch.cmd),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_frame_ok      (out_ch.frame_ok),
  .out_channel_index (out_ch.channel_index),
  .out_channel_value (out_ch.channel_value),
  .out_last          (out_ch.last)
);
